// ===== sv/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants, codes and control structs of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // Number of byte slots in the character store.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = ADDR_W + 1;
  localparam int CHAR_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the accepted transaction
    logic eval;      // latch the status of the command
    logic rd_text;   // read the text byte at the mapped index
    logic capture;   // capture the byte returned by the store
    logic shift_rd;  // read the byte that crosses the gap
    logic shift_wr;  // write it on the far side and slide the gap
    logic apply;     // finish an insert or a delete at the gap
    logic load_out;  // load the result register
  } gbts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fault;       // range fault or full gap
    logic is_read;     // the command is a read
    logic need_left;   // the gap must slide toward the front
    logic need_right;  // the gap must slide toward the back
  } gbts_stat_t;

endpackage

// ===== sv/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// gbts_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gbts_datapath.sv =====
// ----------------------------------------------------------------------------
// gbts_datapath
// Gap bounds, command checks, character store and the result register.
// ----------------------------------------------------------------------------
module gbts_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gbts_pkg::gbts_cmd_t      ctl,
  output gbts_pkg::gbts_stat_t     stat,
  input  logic [gbts_pkg::CMD_W-1:0]  in_command,
  input  logic [gbts_pkg::POS_W-1:0]  in_position,
  input  logic [gbts_pkg::CHAR_W-1:0] in_character,
  output logic [gbts_pkg::STAT_W-1:0] out_status,
  output logic [gbts_pkg::POS_W-1:0]  out_gap_start,
  output logic [gbts_pkg::ADDR_W-1:0] out_gap_end,
  output logic [gbts_pkg::POS_W-1:0]  out_text_length,
  output logic [gbts_pkg::CHAR_W-1:0] out_read_char
);
  import gbts_pkg::*;

  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] char_r;
  logic [POS_W-1:0]  gap_start_r, gap_start_nxt;
  logic [ADDR_W-1:0] gap_end_r, gap_end_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CHAR_W-1:0] rd_char_r;
  logic [STAT_W-1:0] res_status_r;
  logic [POS_W-1:0]  res_gap_start_r;
  logic [ADDR_W-1:0] res_gap_end_r;
  logic [POS_W-1:0]  res_text_len_r;
  logic [CHAR_W-1:0] res_char_r;

  logic [POS_W-1:0]  gap_len;
  logic [POS_W-1:0]  text_len;
  logic [POS_W-1:0]  read_idx;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;

  assign gap_len  = {1'b0, gap_end_r} - gap_start_r + POS_W'(1);
  assign text_len = POS_W'(CAPACITY) - gap_len;
  // Logical index to store index: indexes at or past the gap skip over it.
  assign read_idx = (pos_r >= gap_start_r) ? pos_r + gap_len : pos_r;

  assign stat.is_read    = (cmd_r == CMD_READ);
  assign stat.need_left  = (pos_r < gap_start_r);
  assign stat.need_right = (pos_r > gap_start_r);
  assign stat.fault      = (status_nxt != ST_DONE);

  // Status of the command against the gap as it stands before the command.
  always_comb begin
    status_nxt = ST_DONE;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (pos_r > text_len) begin
          status_nxt = ST_RANGE;
        end else if (gap_start_r == {1'b0, gap_end_r}) begin
          status_nxt = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (pos_r == '0 || pos_r > text_len) begin
          status_nxt = ST_RANGE;
        end
      end
      CMD_MOVE: begin
        if (pos_r > text_len) begin
          status_nxt = ST_RANGE;
        end
      end
      CMD_READ: begin
        if (pos_r >= text_len) begin
          status_nxt = ST_RANGE;
        end
      end
      default: status_nxt = ST_RANGE;
    endcase
  end

  // Store port: one access per cycle, chosen by the controller's command.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = gap_start_r[ADDR_W-1:0];
    mem_wdata = mem_rdata;
    if (ctl.rd_text) begin
      mem_addr = read_idx[ADDR_W-1:0];
    end else if (ctl.shift_rd) begin
      mem_addr = stat.need_left ? ADDR_W'(gap_start_r - POS_W'(1))
                                : gap_end_r + ADDR_W'(1);
    end else if (ctl.shift_wr) begin
      mem_we   = 1'b1;
      mem_addr = stat.need_left ? gap_end_r : gap_start_r[ADDR_W-1:0];
    end else if (ctl.apply && cmd_r == CMD_INSERT) begin
      mem_we    = 1'b1;
      mem_wdata = char_r;
    end
  end

  always_comb begin
    gap_start_nxt = gap_start_r;
    gap_end_nxt   = gap_end_r;
    if (ctl.shift_wr) begin
      if (stat.need_left) begin
        gap_start_nxt = gap_start_r - POS_W'(1);
        gap_end_nxt   = gap_end_r - ADDR_W'(1);
      end else begin
        gap_start_nxt = gap_start_r + POS_W'(1);
        gap_end_nxt   = gap_end_r + ADDR_W'(1);
      end
    end else if (ctl.apply) begin
      if (cmd_r == CMD_INSERT) begin
        gap_start_nxt = gap_start_r + POS_W'(1);
      end else if (cmd_r == CMD_DELETE) begin
        gap_start_nxt = gap_start_r - POS_W'(1);
      end
    end
  end

  gbts_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_start_r <= '0;
      gap_end_r   <= ADDR_W'(CAPACITY - 1);
    end else begin
      gap_start_r <= gap_start_nxt;
      gap_end_r   <= gap_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r  <= in_command;
      pos_r  <= in_position;
      char_r <= in_character;
    end
    if (ctl.eval) begin
      status_r  <= status_nxt;
      rd_char_r <= '0;
    end else if (ctl.capture) begin
      rd_char_r <= mem_rdata;
    end
    if (ctl.load_out) begin
      res_status_r    <= status_r;
      res_gap_start_r <= gap_start_r;
      res_gap_end_r   <= gap_end_r;
      res_text_len_r  <= text_len;
      res_char_r      <= rd_char_r;
    end
  end

  assign out_status      = res_status_r;
  assign out_gap_start   = res_gap_start_r;
  assign out_gap_end     = res_gap_end_r;
  assign out_text_length = res_text_len_r;
  assign out_read_char   = res_char_r;

  // The gap always keeps at least one slot.
  a_gap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    gap_start_r <= {1'b0, gap_end_r})
    else $error("gap start passed gap end");

  // Sliding the gap by one byte keeps its size.
  a_shift_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_wr |=> gap_len == $past(gap_len))
    else $error("gap size changed during a shift");

  // A byte is only captured for a read that passed its range check.
  a_capture_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |-> (status_r == ST_DONE && cmd_r == CMD_READ))
    else $error("byte captured for a failed or non-read command");

endmodule

// ===== sv/gbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbts_ctrl
// Command sequencer: checks, gap shifting loop, result handoff.
// ----------------------------------------------------------------------------
module gbts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output gbts_pkg::gbts_cmd_t   ctl,
  input  gbts_pkg::gbts_stat_t  stat
);
  import gbts_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_RDWAIT   = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_APPLY    = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        if (stat.fault) begin
          state_nxt = S_FINISH;
        end else if (stat.is_read) begin
          ctl.rd_text = 1'b1;
          state_nxt   = S_RDWAIT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_RDWAIT: begin
        ctl.capture = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_SHIFT: begin
        if (stat.need_left || stat.need_right) begin
          ctl.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_SHIFT_WR: begin
        ctl.shift_wr = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // An accepted transaction is always evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_EVAL)
    else $error("accepted transaction not evaluated");

  // A store write always follows the read that fetched its byte.
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_wr |-> $past(ctl.shift_rd))
    else $error("shift write without a preceding read");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule

// ===== sv/gap_buffer_text_store.sv =====
// Path, accept to out_tvalid: a refused command passes EVAL and FINISH, a read
// EVAL, RDWAIT and FINISH; insert, delete and move pass EVAL, then SHIFT and
// SHIFT_WR for each byte the gap slides, then APPLY and FINISH. One transaction is
// handled at a time; the next is accepted in the cycle after the result is loaded.
// Reset (rst_n low, synchronous): empty text, gap spans the whole store, no result
// pending. The character store itself is not cleared; no slot is read before written.
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap buffer for text editing with insert, delete, move and read
// commands, each answered by one result transaction.
// ----------------------------------------------------------------------------
module gap_buffer_text_store (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: position[10:0], character[18:11], zero padding[23:19].
  input  logic [gbts_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: command[1:0].
  input  logic [gbts_pkg::CMD_W-1:0]      in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: status[1:0], gap_start_out[12:2], gap_end_out[22:13],
  // text_length[33:23], read_char[41:34], zero padding[47:42].
  output logic [gbts_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gbts_pkg::*;

  gbts_cmd_t  ctl;
  gbts_stat_t stat;

  logic [STAT_W-1:0] res_status;
  logic [POS_W-1:0]  res_gap_start;
  logic [ADDR_W-1:0] res_gap_end;
  logic [POS_W-1:0]  res_text_len;
  logic [CHAR_W-1:0] res_char;

  // The controller walks each command through its check, the gap slide loop
  // (one read and one write of the store per byte moved) and the final edit.
  gbts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  // The datapath holds the gap bounds, the store and the result register,
  // so a finished result can wait while the next transaction is accepted.
  gbts_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_tuser),
    .in_position     (in_tdata[POS_W-1:0]),
    .in_character    (in_tdata[POS_W+CHAR_W-1:POS_W]),
    .out_status      (res_status),
    .out_gap_start   (res_gap_start),
    .out_gap_end     (res_gap_end),
    .out_text_length (res_text_len),
    .out_read_char   (res_char)
  );

  // Pack the result fields from the lowest bit up.
  assign out_tdata = {
    (OUT_DATA_W - STAT_W - POS_W - ADDR_W - POS_W - CHAR_W)'(0),
    res_char, res_text_len, res_gap_end, res_gap_start, res_status
  };

endmodule

// ===== tb/gap_buffer_text_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Self-checking bench for the gap buffer text store. It drives insert, delete,
// move and read commands over the command stream and tracks the text in a
// behavioral model. Every result transaction is compared field by field with
// the model's answer.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test;
  import gbts_pkg::*;

  // Clock period is 12 ns. The hold-off below is long enough for the block to
  // fill up and stall its command channel.
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_POS      = 2047;

  // One result transaction split into its fields.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  gap_start;
    logic [ADDR_W-1:0] gap_end;
    logic [POS_W-1:0]  text_len;
    logic [CHAR_W-1:0] read_char;
  } edit_reply_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = CMD_INSERT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Behavioral view of the text: the characters in logical order and the
  // cursor, which is where the gap starts.
  byte unsigned doc_text[$];
  int unsigned  doc_cursor = 0;

  // Answers that the block still owes, oldest first.
  edit_reply_t  owed_replies[$];
  int unsigned  mismatch_count = 0;

  // Sender pacing. While sender_steady is set the sender offers back to back.
  int unsigned  burst_left    = 0;
  bit           sender_steady = 1'b0;

  // Receiver pacing. A hold-off is requested by bumping hold_requests; the
  // receiver process counts the stall itself.
  int unsigned  hold_requests = 0;
  int unsigned  hold_served   = 0;
  int unsigned  hold_left     = 0;
  int unsigned  stall_mode    = 0;
  int unsigned  stall_left    = 0;
  int unsigned  stall_tick    = 0;

  gap_buffer_text_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one command to the text model and returns the result it should
  // produce. A refused command leaves the text and the cursor untouched, and
  // a range fault wins over a full gap.
  function automatic edit_reply_t predict_edit(logic [CMD_W-1:0] cmd, int unsigned pos,
                                               logic [CHAR_W-1:0] ch);
    edit_reply_t reply;
    int unsigned len;
    len = doc_text.size();
    reply = '0;
    reply.status = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (pos > len) begin
          reply.status = ST_RANGE;
        end else if (len == CAPACITY - 1) begin
          reply.status = ST_FULL;
        end else begin
          doc_text.insert(pos, ch);
          doc_cursor = pos + 1;
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || pos > len) begin
          reply.status = ST_RANGE;
        end else begin
          doc_text.delete(pos - 1);
          doc_cursor = pos - 1;
        end
      end
      CMD_MOVE: begin
        if (pos > len) begin
          reply.status = ST_RANGE;
        end else begin
          doc_cursor = pos;
        end
      end
      default: begin
        if (pos >= len) begin
          reply.status = ST_RANGE;
        end else begin
          reply.read_char = doc_text[pos];
        end
      end
    endcase
    // The gap holds every slot the text does not use, starting at the cursor.
    reply.gap_start = POS_W'(doc_cursor);
    reply.text_len  = POS_W'(doc_text.size());
    reply.gap_end   = ADDR_W'(doc_cursor + (CAPACITY - doc_text.size()) - 1);
    return reply;
  endfunction

  // A position a few characters either side of the cursor, kept within top.
  // Short slides keep the run fast; far slides come from uniform picks.
  function automatic int unsigned near_cursor(int unsigned span, int unsigned top);
    int signed p;
    p = int'(doc_cursor) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (p < 0) p = 0;
    if (p > int'(top)) p = top;
    return p;
  endfunction

  // Offers one command and waits for its transaction. Between bursts the
  // sender drops tvalid for a random number of cycles. The expectation is
  // recorded at the accepting edge, so the model always matches the block's
  // order of commands.
  task automatic send_edit(logic [CMD_W-1:0] cmd, int unsigned pos, logic [CHAR_W-1:0] ch);
    int unsigned idle;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (idle != 0) begin
          in_tvalid <= 1'b0;
          repeat (idle) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, ch, pos[POS_W-1:0]};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    owed_replies.push_back(predict_edit(cmd, pos[POS_W-1:0], ch));
  endtask

  // Edge cases on an empty and a short text: every command, refused commands
  // at the start and past the end, slides in both directions, the largest
  // position the field can carry, and both extreme byte values.
  task automatic test_directed_edges();
    send_edit(CMD_READ,   0, 8'h00);
    send_edit(CMD_DELETE, 0, 8'h00);
    send_edit(CMD_DELETE, 1, 8'h00);
    send_edit(CMD_MOVE,   1, 8'h00);
    send_edit(CMD_INSERT, 1, 8'h11);
    send_edit(CMD_INSERT, 0, 8'h00);
    send_edit(CMD_INSERT, 1, 8'hFF);
    send_edit(CMD_INSERT, 0, 8'hA5);
    send_edit(CMD_READ,   0, 8'h00);
    send_edit(CMD_READ,   2, 8'h00);
    send_edit(CMD_READ,   3, 8'h00);
    send_edit(CMD_MOVE,   3, 8'h00);
    send_edit(CMD_MOVE,   0, 8'h00);
    send_edit(CMD_MOVE,   2, 8'h00);
    send_edit(CMD_DELETE, 3, 8'h00);
    send_edit(CMD_DELETE, 1, 8'h00);
    send_edit(CMD_INSERT, MAX_POS, 8'h7E);
    send_edit(CMD_MOVE,   MAX_POS, 8'h00);
    send_edit(CMD_DELETE, MAX_POS, 8'h00);
    send_edit(CMD_READ,   MAX_POS, 8'h00);
    send_edit(CMD_READ,   CAPACITY, 8'h00);
    send_edit(CMD_INSERT, 1, 8'h5A);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // commands back to back, so results back up and the command channel stalls.
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    sender_steady = 1'b1;
    repeat (10) send_edit(CMD_INSERT, doc_cursor, CHAR_W'($urandom_range(0, 255)));
    send_edit(CMD_READ, 0, 8'h00);
    sender_steady = 1'b0;
  endtask

  // Mostly well-formed edits near the cursor, now and then anywhere in the
  // text, plus a little noise with arbitrary fields. The mix of inserts and
  // deletes is redrawn every hundred commands so the text grows and shrinks.
  task automatic test_random_edits(int unsigned count);
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned len;
    int unsigned top;
    int unsigned pick;
    int unsigned pos;
    logic [CMD_W-1:0] cmd;
    ins_w = 40;
    del_w = 20;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        ins_w = $urandom_range(10, 60);
        del_w = $urandom_range(10, 60);
      end
      len = doc_text.size();
      if ($urandom_range(0, 99) < 8) begin
        send_edit(CMD_W'($urandom_range(0, 3)), $urandom_range(0, MAX_POS),
                  CHAR_W'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, ins_w + del_w + 39);
        if (pick < ins_w) cmd = CMD_INSERT;
        else if (pick < ins_w + del_w) cmd = CMD_DELETE;
        else if (pick < ins_w + del_w + 15) cmd = CMD_MOVE;
        else cmd = CMD_READ;
        top = (cmd == CMD_READ && len > 0) ? len - 1 : len;
        if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, top);
        else pos = near_cursor(8, top);
        if (cmd == CMD_DELETE && pos == 0 && len > 0) pos = 1;
        send_edit(cmd, pos, CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Fills the store until the gap is down to its last slot, then checks that
  // inserts are refused, that a range fault is reported ahead of a full gap,
  // and that slides across the whole text still work.
  task automatic test_full_gap();
    int unsigned pos;
    while (doc_text.size() < CAPACITY - 1) begin
      pos = ($urandom_range(0, 9) == 0) ? near_cursor(4, doc_text.size()) : doc_cursor;
      send_edit(CMD_INSERT, pos, CHAR_W'($urandom_range(0, 255)));
    end
    send_edit(CMD_INSERT, doc_cursor, 8'h41);
    send_edit(CMD_INSERT, CAPACITY, 8'h42);
    send_edit(CMD_INSERT, 0, 8'h43);
    send_edit(CMD_READ,   CAPACITY - 2, 8'h00);
    send_edit(CMD_READ,   CAPACITY - 1, 8'h00);
    send_edit(CMD_MOVE,   0, 8'h00);
    send_edit(CMD_READ,   0, 8'h00);
    send_edit(CMD_MOVE,   CAPACITY - 1, 8'h00);
    send_edit(CMD_MOVE,   CAPACITY, 8'h00);
    send_edit(CMD_DELETE, CAPACITY, 8'h00);
    send_edit(CMD_DELETE, CAPACITY - 1, 8'h00);
    send_edit(CMD_INSERT, 0, 8'hC3);
    send_edit(CMD_INSERT, 1, 8'h3C);
  endtask

  // Receiver readiness. A requested hold-off wins; otherwise the receiver
  // switches at random between always ready, coin flips, ready on tick counts
  // divisible by three, and mostly ready.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(32, 256);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (stall_tick % 3 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result checker. Every accepted result is matched against the oldest
  // answer still owed.
  always @(posedge clk) begin : check_replies
    edit_reply_t got;
    edit_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status    = out_tdata[1:0];
      got.gap_start = out_tdata[12:2];
      got.gap_end   = out_tdata[22:13];
      got.text_len  = out_tdata[33:23];
      got.read_char = out_tdata[41:34];
      if (owed_replies.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with none pending: status %0d gap %0d..%0d len %0d %s",
                   $realtime, got.status, got.gap_start, got.gap_end, got.text_len,
                   $sformatf("char %02h", got.read_char));
        mismatch_count++;
      end else begin
        want = owed_replies.pop_front();
        if (got.status != want.status || got.gap_start != want.gap_start ||
            got.gap_end != want.gap_end || got.text_len != want.text_len ||
            got.read_char != want.read_char) begin
          if (mismatch_count < 10)
            $display("%0t: expected status %0d gap %0d..%0d len %0d char %02h, %s",
                     $realtime, want.status, want.gap_start, want.gap_end, want.text_len,
                     want.read_char,
                     $sformatf("got %0d %0d..%0d %0d %02h", got.status, got.gap_start,
                               got.gap_end, got.text_len, got.read_char));
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_backpressure();
    test_random_edits(200);
    test_full_gap();
    test_random_edits(100);

    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    repeat (20_000_000) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
